### rtl/core/dda_pkg.sv
// Shared types and constants for the detection decode and argmax filter.
package dda_pkg;

    localparam int MAX_CLASSES_DEFAULT     = 128;
    localparam int MAX_MASK_COEFFS_DEFAULT = 64;

    localparam int FEATURE_W   = 32;
    localparam int EDGE_W      = 17;
    localparam int SCORE_W     = 31;
    localparam int CLASS_W     = 8;
    localparam int NUM_CLS_W   = 8;
    localparam int MASK_CNT_W  = 7;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 31;
    localparam int OUT_DATA_W  = 144;

    localparam logic [NUM_CLS_W-1:0]  NUM_CLASSES_RESET    = 8'd80;
    localparam logic [MASK_CNT_W-1:0] MASK_COUNT_RESET     = 7'd32;
    localparam logic [SCORE_W-1:0]    CONF_THRESHOLD_RESET = 31'd16384;
    localparam logic [CLASS_W-1:0]    NO_CLASS             = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_CLASSES    = 2'd0,
        REG_MASK_COUNT     = 2'd1,
        REG_CONF_THRESHOLD = 2'd2
    } reg_index_t;

    localparam logic KIND_HEADER = 1'b0;
    localparam logic KIND_MASK   = 1'b1;

    typedef struct packed {
        logic [NUM_CLS_W-1:0]  class_count;
        logic [MASK_CNT_W-1:0] mask_count;
        logic [SCORE_W-1:0]    conf_threshold;
    } cfg_t;

    typedef struct packed {
        logic                        kind;
        logic signed [EDGE_W-1:0]    left;
        logic signed [EDGE_W-1:0]    top;
        logic signed [EDGE_W-1:0]    box_width;
        logic signed [EDGE_W-1:0]    box_height;
        logic [SCORE_W-1:0]          score;
        logic signed [CLASS_W-1:0]   class_id;
        logic signed [FEATURE_W-1:0] coefficient;
        logic                        last;
    } result_t;

endpackage

### rtl/core/dda_round.sv
// Round half away from zero dropping 17 fraction bits, saturated to 17 signed bits.
module dda_round
    import dda_pkg::*;
(
    input  logic signed [33:0]       value,
    output logic signed [EDGE_W-1:0] rounded
);

    localparam logic signed [17:0] SAT_LO = -18'sd65536;
    localparam logic signed [17:0] SAT_HI = 18'sd65535;

    logic signed [34:0] bias;
    logic signed [34:0] sum;
    logic signed [17:0] shifted;

    // negative values take half minus one, which rounds ties away from zero
    assign bias    = value[33] ? 35'sh0FFFF : 35'sh10000;
    assign sum     = {value[33], value} + bias;
    assign shifted = sum[34:17];

    always_comb
    begin
        if (shifted < SAT_LO)
        begin
            rounded = SAT_LO[EDGE_W-1:0];
        end
        else if (shifted > SAT_HI)
        begin
            rounded = SAT_HI[EDGE_W-1:0];
        end
        else
        begin
            rounded = shifted[EDGE_W-1:0];
        end
    end

endmodule

### rtl/core/dda_decode.sv
// Box position tracking, argmax over class scores and result formation.
module dda_decode
    import dda_pkg::*;
#(
    parameter int MAX_CLASSES     = MAX_CLASSES_DEFAULT,
    parameter int MAX_MASK_COEFFS = MAX_MASK_COEFFS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cfg_t                 cfg,
    input  logic                 fire,
    input  logic [FEATURE_W-1:0] feature,
    output logic                 res_valid,
    output result_t              res
);

    localparam int CLS_W = $clog2(MAX_CLASSES + 1);
    localparam int MSK_W = $clog2(MAX_MASK_COEFFS + 1);
    localparam int POS_W = $clog2(4 + MAX_CLASSES + MAX_MASK_COEFFS + 1);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [FEATURE_W-1:0] bv_reg [4];
    logic [FEATURE_W-1:0] bv_next [4];
    logic [SCORE_W-1:0]   best_reg, best_next;
    logic [CLASS_W-1:0]   cls_reg, cls_next;
    logic                 acc_reg, acc_next;

    logic [CLS_W-1:0]     nc_eff;
    logic [MSK_W-1:0]     mc_eff;
    logic [POS_W-1:0]     total;
    logic [POS_W-1:0]     p;
    logic                 in_box;
    logic                 in_cls;
    logic                 beats;
    logic [SCORE_W-1:0]   best_cur, best_new;
    logic [CLASS_W-1:0]   cls_cur, cls_new;
    logic                 acc_cur;
    logic                 is_hdr;
    logic                 is_mask;
    logic signed [33:0]   left_v, top_v, w_v, h_v;
    logic signed [EDGE_W-1:0] left_r, top_r, w_r, h_r;

    always_comb
    begin
        if (cfg.class_count == '0)
        begin
            nc_eff = CLS_W'(1);
        end
        else if (32'(cfg.class_count) > 32'(MAX_CLASSES))
        begin
            nc_eff = CLS_W'(MAX_CLASSES);
        end
        else
        begin
            nc_eff = CLS_W'(cfg.class_count);
        end

        if (cfg.mask_count == '0)
        begin
            mc_eff = MSK_W'(1);
        end
        else if (32'(cfg.mask_count) > 32'(MAX_MASK_COEFFS))
        begin
            mc_eff = MSK_W'(MAX_MASK_COEFFS);
        end
        else
        begin
            mc_eff = MSK_W'(cfg.mask_count);
        end
    end

    assign total = POS_W'(4) + POS_W'(nc_eff) + POS_W'(mc_eff);
    // a position past the end of the box after a count change starts a new box
    assign p     = (pos_reg >= total) ? '0 : pos_reg;

    assign in_box = p < POS_W'(4);
    assign in_cls = !in_box && (p < POS_W'(4) + POS_W'(nc_eff));

    assign best_cur = (p == '0) ? '0 : best_reg;
    assign cls_cur  = (p == '0) ? NO_CLASS : cls_reg;
    assign acc_cur  = (p == '0) ? 1'b0 : acc_reg;

    assign beats    = in_cls && !feature[FEATURE_W-1] && (feature[SCORE_W-1:0] > best_cur);
    assign best_new = beats ? feature[SCORE_W-1:0] : best_cur;
    assign cls_new  = beats ? CLASS_W'(p - POS_W'(4)) : cls_cur;

    assign is_hdr  = in_cls && (p == POS_W'(3) + POS_W'(nc_eff))
                     && (best_new >= cfg.conf_threshold);
    assign is_mask = !in_box && !in_cls && acc_cur;

    // corners use doubled centers so the half size stays exact
    assign left_v = {bv_reg[0][31], bv_reg[0], 1'b0} - {{2{bv_reg[2][31]}}, bv_reg[2]};
    assign top_v  = {bv_reg[1][31], bv_reg[1], 1'b0} - {{2{bv_reg[3][31]}}, bv_reg[3]};
    assign w_v    = {bv_reg[2][31], bv_reg[2], 1'b0};
    assign h_v    = {bv_reg[3][31], bv_reg[3], 1'b0};

    dda_round u_round_left (.value(left_v), .rounded(left_r));
    dda_round u_round_top  (.value(top_v),  .rounded(top_r));
    dda_round u_round_w    (.value(w_v),    .rounded(w_r));
    dda_round u_round_h    (.value(h_v),    .rounded(h_r));

    always_comb
    begin
        res       = '0;
        res_valid = is_hdr || is_mask;
        if (is_hdr)
        begin
            res.kind       = KIND_HEADER;
            res.left       = left_r;
            res.top        = top_r;
            res.box_width  = w_r;
            res.box_height = h_r;
            res.score      = best_new;
            res.class_id   = cls_new;
        end
        else if (is_mask)
        begin
            res.kind        = KIND_MASK;
            res.coefficient = feature;
            res.last        = (p == total - POS_W'(1));
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        bv_next   = bv_reg;
        best_next = best_reg;
        cls_next  = cls_reg;
        acc_next  = acc_reg;
        if (fire)
        begin
            pos_next  = (p + POS_W'(1) >= total) ? '0 : p + POS_W'(1);
            best_next = best_new;
            cls_next  = cls_new;
            acc_next  = acc_cur || is_hdr;
            if (in_box)
            begin
                bv_next[p[1:0]] = feature;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            bv_reg   <= '{default: '0};
            best_reg <= '0;
            cls_reg  <= NO_CLASS;
            acc_reg  <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            bv_reg   <= bv_next;
            best_reg <= best_next;
            cls_reg  <= cls_next;
            acc_reg  <= acc_next;
        end
    end

    a_mask_needs_header: assert property (@(posedge clk) disable iff (!rst_n)
        is_mask |-> acc_reg && (pos_reg != '0))
        else $error("mask word without an accepted header");

    a_header_meets_threshold: assert property (@(posedge clk) disable iff (!rst_n)
        is_hdr |-> best_new >= cfg.conf_threshold)
        else $error("header emitted below threshold");

    a_accept_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_hdr |=> acc_reg)
        else $error("accept flag not set after header");

    a_last_on_mask_only: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.last |-> res.kind == KIND_MASK)
        else $error("last flag on a header word");

endmodule

### rtl/core/detection_decode_argmax_filter.sv
// Top level of the detection decode and argmax filter with stream ports.
//
// Feature words enter on the s_ side in box order: center x, center y, width,
// height, class_count class scores, then mask_count mask coefficients, all
// signed Q16.16. One word is taken every cycle; each word passes an input
// register, the decode logic and a result register, and m_tready low stalls
// the input only once both registers are full. A box whose best score
// reaches conf_threshold yields one header word (tuser 0) on its last class
// score, then one word per mask coefficient (tuser 1), the final one with
// tlast. Rejected boxes and the other box and score words yield nothing.
// Configuration is taken every cycle on the cfg_ channel and should change
// only while idle.
module detection_decode_argmax_filter
    import dda_pkg::*;
#(
    parameter int MAX_CLASSES     = MAX_CLASSES_DEFAULT,
    parameter int MAX_MASK_COEFFS = MAX_MASK_COEFFS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [FEATURE_W-1:0]  s_tdata,   // [31:0] feature
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [16:0] left, [33:17] top, [50:34] box_width, [67:51] box_height,
    // [98:68] score, [106:99] class_id, [138:107] coefficient, [143:139] zero
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [0:0]            m_tuser,   // [0] kind
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t                 cfg_reg;
    logic                 in_vld_reg;
    logic [FEATURE_W-1:0] in_data_reg;
    logic                 out_vld_reg, out_vld_next;
    result_t              out_reg;
    logic                 go;
    logic                 res_valid;
    result_t              res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.class_count    <= NUM_CLASSES_RESET;
            cfg_reg.mask_count     <= MASK_COUNT_RESET;
            cfg_reg.conf_threshold <= CONF_THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NUM_CLASSES:    cfg_reg.class_count    <= cfg_data[NUM_CLS_W-1:0];
                REG_MASK_COUNT:     cfg_reg.mask_count     <= cfg_data[MASK_CNT_W-1:0];
                REG_CONF_THRESHOLD: cfg_reg.conf_threshold <= cfg_data[SCORE_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // advance the held word whenever the result register is free or draining
    assign go       = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

    dda_decode #(
        .MAX_CLASSES     (MAX_CLASSES),
        .MAX_MASK_COEFFS (MAX_MASK_COEFFS)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (go),
        .feature   (in_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        if (go)
        begin
            out_vld_next = res_valid;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'b0, out_reg.coefficient, out_reg.class_id, out_reg.score,
                       out_reg.box_height, out_reg.box_width, out_reg.top, out_reg.left};

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Stream testbench for the detection decode and argmax filter, checked word by word.
module tb;
    import dda_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 20;
    localparam int SEG_WORDS      = 40;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {
        STIM_FEATURE,
        STIM_REG_WRITE,
        STIM_IDLE_MODE
    } stim_kind_t;

    typedef struct {
        stim_kind_t           kind;
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          value;
    } stim_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [FEATURE_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    stim_t   feed_q [$];
    result_t det_queue [$];

    // model copy of the registers and the per-box state
    logic [NUM_CLS_W-1:0]  cur_classes = NUM_CLASSES_RESET;
    logic [MASK_CNT_W-1:0] cur_masks = MASK_COUNT_RESET;
    logic [SCORE_W-1:0]    cur_threshold = CONF_THRESHOLD_RESET;
    int unsigned           feat_pos = 0;
    logic [31:0]           box_word [4] = '{default: '0};
    longint                best_score = 0;
    int                    best_class = -1;
    bit                    box_kept = 1'b0;

    bit feature_taken = 1'b0;
    bit reg_taken = 1'b0;
    int sender_idle = 0;
    int receiver_idle = 0;
    int quiet_cycles = 0;
    int settle_cycles = 0;
    int tail_cycles = 0;
    int fail_count = 0;
    bit tail_done = 1'b0;
    bit hung = 1'b0;

    logic [31:0] opening_words [30] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_8000, 32'hFFFE_8000,
        32'h0000_4000, 32'h0000_4000, 32'hFFFF_FFFF, 32'h8000_0000,
        32'h0000_4000, 32'h0000_4000, 32'h0000_8000, 32'hFFFF_8000,
        32'h0000_3FFF, 32'h8000_0000, 32'h1234_5678, 32'h0000_0000,
        32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
        32'h0000_0001, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A,
        32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000, 32'h0002_0000,
        32'hFFFF_FFFB, 32'h5555_5555
    };

    detection_decode_argmax_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int unsigned eff_count(input int unsigned written,
                                              input int unsigned ceiling);
        if (written == 0)
            return 1;
        if (written > ceiling)
            return ceiling;
        return written;
    endfunction

    // round half away from zero, dropping frac fraction bits, then saturate
    function automatic longint round_pixels(input longint v, input int frac);
        longint half;
        longint r;
        half = longint'(1) << (frac - 1);
        if (v >= 0)
            r = (v + half) >>> frac;
        else
            r = -((-v + half) >>> frac);
        if (r < -65536)
            r = -65536;
        if (r > 65535)
            r = 65535;
        return r;
    endfunction

    function automatic void decode_feature(input logic [FEATURE_W-1:0] word);
        int unsigned n_cls;
        int unsigned n_msk;
        int unsigned box_len;
        longint      val;
        longint      cx;
        longint      cy;
        longint      w;
        longint      h;
        result_t     det;
        n_cls = eff_count(cur_classes, MAX_CLASSES_DEFAULT);
        n_msk = eff_count(cur_masks, MAX_MASK_COEFFS_DEFAULT);
        box_len = 4 + n_cls + n_msk;
        val = longint'($signed(word));
        det = '0;
        // a shrunk box length restarts the box
        if (feat_pos >= box_len)
            feat_pos = 0;
        if (feat_pos == 0)
        begin
            best_score = 0;
            best_class = -1;
            box_kept = 1'b0;
        end
        if (feat_pos < 4)
            box_word[feat_pos] = word;
        else if (feat_pos < 4 + n_cls)
        begin
            if (val > best_score)
            begin
                best_score = val;
                best_class = feat_pos - 4;
            end
            if (feat_pos == 3 + n_cls && best_score >= longint'(cur_threshold))
            begin
                cx = longint'($signed(box_word[0]));
                cy = longint'($signed(box_word[1]));
                w = longint'($signed(box_word[2]));
                h = longint'($signed(box_word[3]));
                box_kept = 1'b1;
                det.kind = KIND_HEADER;
                det.left = EDGE_W'(round_pixels(2 * cx - w, 17));
                det.top = EDGE_W'(round_pixels(2 * cy - h, 17));
                det.box_width = EDGE_W'(round_pixels(w, 16));
                det.box_height = EDGE_W'(round_pixels(h, 16));
                det.score = best_score[SCORE_W-1:0];
                det.class_id = best_class[CLASS_W-1:0];
                det_queue.insert(det_queue.size(), det);
            end
        end
        else if (box_kept)
        begin
            det.kind = KIND_MASK;
            det.coefficient = word;
            det.last = (feat_pos == box_len - 1);
            det_queue.insert(det_queue.size(), det);
        end
        feat_pos = (feat_pos + 1 >= box_len) ? 0 : feat_pos + 1;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input longint got, input longint want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic push_feature(input logic [31:0] v);
        stim_t e;
        e.kind = STIM_FEATURE;
        e.index = '0;
        e.value = v;
        feed_q.insert(feed_q.size(), e);
    endtask

    task automatic push_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        stim_t e;
        e.kind = STIM_REG_WRITE;
        e.index = idx;
        e.value = v;
        feed_q.insert(feed_q.size(), e);
    endtask

    task automatic push_idle(input int sender_pct, input int receiver_pct);
        stim_t e;
        e.kind = STIM_IDLE_MODE;
        e.index = '0;
        e.value = {16'd0, 8'(receiver_pct), 8'(sender_pct)};
        feed_q.insert(feed_q.size(), e);
    endtask

    function automatic logic [31:0] pick_coord();
        int          ip;
        logic [15:0] frac;
        if ($urandom_range(3) == 0)
            return $urandom;
        ip = int'($urandom_range(0, 1200)) - 600;
        case ($urandom_range(2))
            0: frac = 16'h8000;
            1: frac = 16'h0000;
            default: frac = 16'($urandom);
        endcase
        return {ip[15:0], frac};
    endfunction

    function automatic logic [31:0] pick_score(input logic [SCORE_W-1:0] thr);
        case ($urandom_range(7))
            0: return $urandom;
            1: return 32'h0;
            2: return 32'(0 - $urandom_range(1, 4096));
            3: return 32'h7FFF_FFFF;
            4: return 32'h8000_0000;
            default: return {1'b0, thr} + $urandom_range(0, 4) - 2;
        endcase
    endfunction

    // queue the first count words of one box laid out for the given sizes
    task automatic push_box(input int unsigned n_cls, input int unsigned n_msk,
                            input logic [SCORE_W-1:0] thr, input int unsigned count);
        for (int unsigned p = 0; p < count; p++)
        begin
            if (p < 4)
                push_feature(pick_coord());
            else if (p < 4 + n_cls)
                push_feature(pick_score(thr));
            else
                push_feature($urandom);
        end
    endtask

    initial
    begin : build_stimulus
        int unsigned          n_cls;
        int unsigned          n_msk;
        int unsigned          seg_words;
        int unsigned          seg;
        logic [NUM_CLS_W-1:0] nc_w;
        logic [MASK_CNT_W-1:0] mc_w;
        logic [SCORE_W-1:0]   thr_w;
        push_idle(23, 60);
        push_reg(REG_NUM_CLASSES, 32'd2);
        push_reg(REG_MASK_COUNT, 32'd2);
        for (int i = 0; i < 24; i++)
            push_feature(opening_words[i]);
        // zero threshold and single class: a box with no positive score still passes
        push_reg(REG_CONF_THRESHOLD, 32'd0);
        push_reg(REG_NUM_CLASSES, 32'd1);
        push_reg(REG_MASK_COUNT, 32'd1);
        for (int i = 24; i < 30; i++)
            push_feature(opening_words[i]);

        for (int g = 0; g < 3; g++)
        begin
            if (g == 1)
                push_idle(60, 23);
            else if (g == 2)
                push_idle(0, 0);
            for (int k = 0; k < 3; k++)
            begin
                seg = g * 3 + k;
                nc_w = NUM_CLS_W'($urandom_range(1, 8));
                mc_w = MASK_CNT_W'($urandom_range(1, 6));
                case ($urandom_range(2))
                    0: thr_w = SCORE_W'($urandom_range(0, 32'h0002_0000));
                    1: thr_w = SCORE_W'($urandom);
                    default: thr_w = 31'h0000_4000;
                endcase
                if (seg == 1)
                begin
                    nc_w = 8'hFF;
                    mc_w = 7'h7F;
                    thr_w = SCORE_W'($urandom_range(0, 32'h0003_0000));
                end
                else if (seg == 4)
                begin
                    nc_w = '0;
                    mc_w = '0;
                    thr_w = '0;
                end
                else if (seg == 7)
                    thr_w = 31'h7FFF_FFFF;
                push_reg(REG_NUM_CLASSES, ($urandom & 32'h7FFF_FF00) | nc_w);
                push_reg(REG_MASK_COUNT, ($urandom & 32'h7FFF_FF80) | mc_w);
                push_reg(REG_CONF_THRESHOLD, {1'b0, thr_w});
                if (seg == 3)
                    push_reg(REG_UNUSED, $urandom);
                n_cls = eff_count(nc_w, MAX_CLASSES_DEFAULT);
                n_msk = eff_count(mc_w, MAX_MASK_COEFFS_DEFAULT);
                seg_words = 0;
                while (seg_words < SEG_WORDS)
                begin
                    push_box(n_cls, n_msk, thr_w, 4 + n_cls + n_msk);
                    seg_words += 4 + n_cls + n_msk;
                end
                // sometimes leave a box unfinished so the next setting lands mid-box
                if ($urandom_range(1))
                    push_box(n_cls, n_msk, thr_w, $urandom_range(1, 3 + n_cls + n_msk));
            end
        end
    end

    always @(negedge clk)
    begin : drive_inputs
        logic                  nxt_s_valid;
        logic [FEATURE_W-1:0]  nxt_s_data;
        logic                  nxt_c_valid;
        logic [CFG_IDX_W-1:0]  nxt_c_index;
        logic [CFG_DATA_W-1:0] nxt_c_data;
        stim_t                 head;
        if (rst_n)
        begin
            nxt_s_valid = s_tvalid && !feature_taken;
            nxt_s_data = s_tdata;
            nxt_c_valid = cfg_valid && !reg_taken;
            nxt_c_index = cfg_index;
            nxt_c_data = cfg_data;
            feature_taken = 1'b0;
            reg_taken = 1'b0;
            if (!nxt_s_valid && !nxt_c_valid && feed_q.size() > 0)
            begin
                head = feed_q[0];
                case (head.kind)
                    STIM_IDLE_MODE:
                    begin
                        sender_idle = int'(head.value[7:0]);
                        receiver_idle = int'(head.value[15:8]);
                        void'(feed_q.pop_front());
                    end
                    STIM_REG_WRITE:
                    begin
                        // write only once the pipeline has drained
                        if (det_queue.size() == 0 && settle_cycles >= SETTLE_CYCLES)
                        begin
                            nxt_c_valid = 1'b1;
                            nxt_c_index = head.index;
                            nxt_c_data = head.value[CFG_DATA_W-1:0];
                            void'(feed_q.pop_front());
                        end
                    end
                    default:
                    begin
                        if ($urandom_range(99) >= sender_idle)
                        begin
                            nxt_s_valid = 1'b1;
                            nxt_s_data = head.value;
                            void'(feed_q.pop_front());
                        end
                    end
                endcase
            end
            s_tvalid <= nxt_s_valid;
            s_tdata <= nxt_s_data;
            cfg_valid <= nxt_c_valid;
            cfg_index <= nxt_c_index;
            cfg_data <= nxt_c_data;
            m_tready <= ($urandom_range(99) >= receiver_idle);
        end
    end

    always @(posedge clk)
    begin : watch_outputs
        result_t seen;
        result_t want;
        if (rst_n)
        begin
            quiet_cycles++;
            settle_cycles++;
            // check outputs before this edge's word adds expectations
            if (m_tvalid && m_tready)
            begin
                quiet_cycles = 0;
                settle_cycles = 0;
                seen.kind = m_tuser[0];
                seen.left = m_tdata[16:0];
                seen.top = m_tdata[33:17];
                seen.box_width = m_tdata[50:34];
                seen.box_height = m_tdata[67:51];
                seen.score = m_tdata[98:68];
                seen.class_id = m_tdata[106:99];
                seen.coefficient = m_tdata[138:107];
                seen.last = m_tlast;
                if (det_queue.size() == 0)
                    report_mismatch($sformatf("result word of kind %0d with none expected",
                                              seen.kind));
                else
                begin
                    want = det_queue.pop_front();
                    check_field("kind", seen.kind, want.kind);
                    check_field("left", seen.left, want.left);
                    check_field("top", seen.top, want.top);
                    check_field("box_width", seen.box_width, want.box_width);
                    check_field("box_height", seen.box_height, want.box_height);
                    check_field("score", seen.score, want.score);
                    check_field("class_id", seen.class_id, want.class_id);
                    check_field("coefficient", seen.coefficient, want.coefficient);
                    check_field("last", seen.last, want.last);
                    check_field("pad", m_tdata[143:139], 0);
                end
            end
            if (s_tvalid && s_tready)
            begin
                decode_feature(s_tdata);
                feature_taken = 1'b1;
                quiet_cycles = 0;
                settle_cycles = 0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_NUM_CLASSES:    cur_classes = cfg_data[NUM_CLS_W-1:0];
                    REG_MASK_COUNT:     cur_masks = cfg_data[MASK_CNT_W-1:0];
                    REG_CONF_THRESHOLD: cur_threshold = cfg_data[SCORE_W-1:0];
                    default:            ;
                endcase
                reg_taken = 1'b1;
                quiet_cycles = 0;
            end
            if (feed_q.size() == 0 && !s_tvalid && !cfg_valid && det_queue.size() == 0)
                tail_cycles++;
            else
                tail_cycles = 0;
            if (tail_cycles >= TAIL_CYCLES)
                tail_done = 1'b1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
                hung = 1'b1;
        end
    end

    initial
    begin : run_control
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (tail_done || hung);
        if (hung)
            $display("tb failed");
        else if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
